// ===== hw/rtl/lbm_pkg.sv =====
// ----------------------------------------------------------------------------
// lbm_pkg
// Shared types, constants and helpers for the D2Q9 cell collision pipeline.
// ----------------------------------------------------------------------------
package lbm_pkg;

    // fixed point format and item layout
    localparam int FRAC_BITS  = 28;
    localparam int NDIR       = 9;
    localparam int DIST_W     = 32;
    localparam int IN_DATA_W  = 304;
    localparam int OUT_DATA_W = 288;
    localparam int IN_F_LSB   = 14;
    localparam int VEL_W      = FRAC_BITS + 1;
    localparam int DIV_STEPS  = FRAC_BITS;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [FRAC_BITS:0]   ONE      = (FRAC_BITS+1)'(1) << FRAC_BITS;
    localparam logic [FRAC_BITS-1:0] VEL_HALF = FRAC_BITS'(1) << (FRAC_BITS - 1);

    // lattice weights, rounded to nearest
    localparam longint ONE_L  = longint'(1) << FRAC_BITS;
    localparam logic [27:0] W_REST = 28'((8 * ONE_L + 9) / 18);
    localparam logic [27:0] W_AXIS = 28'((2 * ONE_L + 9) / 18);
    localparam logic [27:0] W_DIAG = 28'((2 * ONE_L + 36) / 72);

    localparam logic signed [71:0] S32_MAX = 72'sd2147483647;
    localparam logic signed [71:0] S32_MIN = -72'sd2147483648;

    // cell kinds
    localparam logic [1:0] KIND_FLUID = 2'd0;
    localparam logic [1:0] KIND_FAN   = 2'd1;
    localparam logic [1:0] KIND_OBST  = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RELAX  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FAN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OBST_X = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OBST_Y = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 3'd4;

    typedef logic [NDIR-1:0][DIST_W-1:0] dvec_t;

    typedef struct packed {
        logic [29:0]       relax_rate;
        logic signed [28:0] fan_velocity;
        logic [7:0]        obstacle_x;
        logic [5:0]        obstacle_y;
        logic [6:0]        obstacle_radius;
    } cfg_t;

    // item travelling through the divider
    typedef struct packed {
        dvec_t                f;
        logic [31:0]          rho;
        logic [1:0]           kind;
        logic                 use_div;
        logic                 neg_x;
        logic                 neg_y;
        logic                 ovf_x;
        logic                 ovf_y;
        logic [30:0]          rem_x;
        logic [30:0]          rem_y;
        logic [FRAC_BITS-1:0] q_x;
        logic [FRAC_BITS-1:0] q_y;
    } div_item_t;

    // item handed to the relaxation stages
    typedef struct packed {
        dvec_t      f;
        dvec_t      feq;
        logic [1:0] kind;
    } rel_item_t;

    // clamp to the signed 32-bit range
    function automatic logic [31:0] sat32(input logic signed [71:0] v);
        logic [31:0] r;
        if (v > S32_MAX)
            r = 32'h7FFF_FFFF;
        else if (v < S32_MIN)
            r = 32'h8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

// ===== hw/rtl/lbm_front.sv =====
// ----------------------------------------------------------------------------
// lbm_front
// Unpacks a cell, forms density and momentum, classifies the cell and
// prepares the two velocity divisions.  Three register stages.
// ----------------------------------------------------------------------------
module lbm_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [lbm_pkg::IN_DATA_W-1:0] in_data,
    input  lbm_pkg::cfg_t               cfg,
    output logic                        out_valid,
    output lbm_pkg::div_item_t          out_item
);

    // stage 1: unpack, obstacle distance terms
    logic               s1_valid_reg;
    logic [7:0]         s1_x_reg;
    lbm_pkg::dvec_t     s1_f_reg;
    logic [15:0]        s1_dx2_reg;
    logic [11:0]        s1_dy2_reg;
    logic               s1_dxz_reg;
    logic               s1_sym_reg;

    logic [7:0]         cx;
    logic [5:0]         cy;
    logic signed [8:0]  dx;
    logic signed [6:0]  dy;
    logic signed [17:0] dx2_full;
    logic signed [13:0] dy2_full;
    logic [7:0]         sym_row;
    lbm_pkg::dvec_t     f_in;

    always_comb
    begin
        cx       = in_data[7:0];
        cy       = in_data[13:8];
        dx       = {1'b0, cx} - {1'b0, cfg.obstacle_x};
        dy       = {1'b0, cy} - {1'b0, cfg.obstacle_y};
        dx2_full = dx * dx;
        dy2_full = dy * dy;
        sym_row  = {2'b0, cfg.obstacle_y} + {1'b0, cfg.obstacle_radius} + 8'd1;
        for (int i = 0; i < lbm_pkg::NDIR; i++)
        begin
            f_in[i] = in_data[lbm_pkg::IN_F_LSB + lbm_pkg::DIST_W*i +: lbm_pkg::DIST_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (en)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_x_reg   <= cx;
            s1_f_reg   <= f_in;
            s1_dx2_reg <= dx2_full[15:0];
            s1_dy2_reg <= dy2_full[11:0];
            s1_dxz_reg <= (dx == 9'sd0);
            s1_sym_reg <= ({2'b0, cy} == sym_row);
        end
    end

    // stage 2: moment sums and cell kind
    logic           s2_valid_reg;
    lbm_pkg::dvec_t s2_f_reg;
    logic [31:0]    s2_rho_reg;
    logic [31:0]    s2_jx_reg;
    logic [31:0]    s2_jy_reg;
    logic [1:0]     s2_kind_reg;

    logic signed [35:0] fe [lbm_pkg::NDIR];
    logic signed [35:0] rho_sum;
    logic signed [35:0] jx_sum;
    logic signed [35:0] jy_sum;
    logic signed [71:0] rho_w;
    logic signed [71:0] jx_w;
    logic signed [71:0] jy_w;
    logic signed [31:0] f_s;
    logic [13:0]        r2;
    logic [16:0]        dist2;
    logic [1:0]         kind;

    always_comb
    begin
        for (int i = 0; i < lbm_pkg::NDIR; i++)
        begin
            f_s   = s1_f_reg[i];
            fe[i] = f_s;
        end
        rho_sum = fe[0] + fe[1] + fe[2] + fe[3] + fe[4] + fe[5] + fe[6] + fe[7] + fe[8];
        jx_sum  = fe[1] - fe[3] + fe[5] - fe[6] - fe[7] + fe[8];
        jy_sum  = fe[2] - fe[4] + fe[5] + fe[6] - fe[7] - fe[8];
        rho_w   = rho_sum;
        jx_w    = jx_sum;
        jy_w    = jy_sum;
        r2      = 14'(cfg.obstacle_radius) * 14'(cfg.obstacle_radius);
        dist2   = 17'(s1_dx2_reg) + 17'(s1_dy2_reg);
        if (s1_x_reg == 8'd0)
            kind = lbm_pkg::KIND_FAN;
        else if ((dist2 <= 17'(r2)) || (s1_dxz_reg && s1_sym_reg))
            kind = lbm_pkg::KIND_OBST;
        else
            kind = lbm_pkg::KIND_FLUID;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (en)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_f_reg    <= s1_f_reg;
            s2_rho_reg  <= lbm_pkg::sat32(rho_w);
            s2_jx_reg   <= lbm_pkg::sat32(jx_w);
            s2_jy_reg   <= lbm_pkg::sat32(jy_w);
            s2_kind_reg <= kind;
        end
    end

    // stage 3: magnitudes, signs and overflow flags for the divider
    logic                s3_valid_reg;
    lbm_pkg::div_item_t  s3_item_reg;
    lbm_pkg::div_item_t  s3_next;
    logic [31:0]         ajx;
    logic [31:0]         ajy;

    always_comb
    begin
        ajx = s2_jx_reg[31] ? (~s2_jx_reg + 32'd1) : s2_jx_reg;
        ajy = s2_jy_reg[31] ? (~s2_jy_reg + 32'd1) : s2_jy_reg;
        s3_next.f       = s2_f_reg;
        s3_next.rho     = s2_rho_reg;
        s3_next.kind    = s2_kind_reg;
        s3_next.use_div = (s2_kind_reg == lbm_pkg::KIND_FLUID) && !s2_rho_reg[31]
                          && (s2_rho_reg != 32'd0);
        s3_next.neg_x   = s2_jx_reg[31];
        s3_next.neg_y   = s2_jy_reg[31];
        s3_next.ovf_x   = (ajx >= s2_rho_reg);
        s3_next.ovf_y   = (ajy >= s2_rho_reg);
        s3_next.rem_x   = ajx[30:0];
        s3_next.rem_y   = ajy[30:0];
        s3_next.q_x     = '0;
        s3_next.q_y     = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_valid_reg <= 1'b0;
        else if (en)
            s3_valid_reg <= s2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            s3_item_reg <= s3_next;
    end

    assign out_valid = s3_valid_reg;
    assign out_item  = s3_item_reg;

endmodule

// ===== hw/rtl/lbm_divider.sv =====
// ----------------------------------------------------------------------------
// lbm_divider
// Pipelined restoring divider: one quotient bit of each velocity per stage.
// ----------------------------------------------------------------------------
module lbm_divider (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  lbm_pkg::div_item_t in_item,
    output logic               out_valid,
    output lbm_pkg::div_item_t out_item
);

    lbm_pkg::div_item_t             link [lbm_pkg::DIV_STEPS+1];
    logic [lbm_pkg::DIV_STEPS:0]    link_valid;
    lbm_pkg::div_item_t             st_item_reg [lbm_pkg::DIV_STEPS];
    logic [lbm_pkg::DIV_STEPS-1:0]  st_valid_reg;

    assign link[0]       = in_item;
    assign link_valid[0] = in_valid;

    for (genvar s = 0; s < lbm_pkg::DIV_STEPS; s++)
    begin : g_step
        lbm_pkg::div_item_t nxt;
        logic [31:0]        rx2;
        logic [31:0]        ry2;
        logic [32:0]        dxr;
        logic [32:0]        dyr;

        // shift, trial subtract, keep the difference on no borrow
        always_comb
        begin
            nxt = link[s];
            rx2 = {link[s].rem_x, 1'b0};
            ry2 = {link[s].rem_y, 1'b0};
            dxr = {1'b0, rx2} - {2'b0, link[s].rho[30:0]};
            dyr = {1'b0, ry2} - {2'b0, link[s].rho[30:0]};
            nxt.rem_x = dxr[32] ? rx2[30:0] : dxr[30:0];
            nxt.rem_y = dyr[32] ? ry2[30:0] : dyr[30:0];
            nxt.q_x = {link[s].q_x[lbm_pkg::DIV_STEPS-2:0], !dxr[32]};
            nxt.q_y = {link[s].q_y[lbm_pkg::DIV_STEPS-2:0], !dyr[32]};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                st_valid_reg[s] <= 1'b0;
            else if (en)
                st_valid_reg[s] <= link_valid[s];
        end

        always_ff @(posedge clk)
        begin
            if (en)
                st_item_reg[s] <= nxt;
        end

        assign link[s+1]       = st_item_reg[s];
        assign link_valid[s+1] = st_valid_reg[s];
    end

    assign out_valid = link_valid[lbm_pkg::DIV_STEPS];
    assign out_item  = link[lbm_pkg::DIV_STEPS];

endmodule

// ===== hw/rtl/lbm_equil.sv =====
// ----------------------------------------------------------------------------
// lbm_equil
// Velocity selection and the nine equilibrium distributions.  Five stages:
// velocity, squares and weighted density, polynomial, partial products, sum.
// ----------------------------------------------------------------------------
module lbm_equil (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  lbm_pkg::div_item_t in_item,
    input  lbm_pkg::cfg_t      cfg,
    output logic               out_valid,
    output lbm_pkg::rel_item_t out_item
);

    localparam int F = lbm_pkg::FRAC_BITS;

    // stage 1: velocity, with saturation and the boundary overrides
    logic                          e1_valid_reg;
    lbm_pkg::dvec_t                e1_f_reg;
    logic [31:0]                   e1_rho_reg;
    logic [1:0]                    e1_kind_reg;
    logic signed [lbm_pkg::VEL_W-1:0] e1_ux_reg;
    logic signed [lbm_pkg::VEL_W-1:0] e1_uy_reg;

    logic [F-1:0]                  mag_x;
    logic [F-1:0]                  mag_y;
    logic signed [lbm_pkg::VEL_W-1:0] vmax;
    logic signed [lbm_pkg::VEL_W-1:0] fan_sat;
    logic signed [lbm_pkg::VEL_W-1:0] ux;
    logic signed [lbm_pkg::VEL_W-1:0] uy;

    always_comb
    begin
        vmax  = {1'b0, lbm_pkg::VEL_HALF};
        mag_x = (in_item.ovf_x || (in_item.q_x > lbm_pkg::VEL_HALF)) ?
                lbm_pkg::VEL_HALF : in_item.q_x;
        mag_y = (in_item.ovf_y || (in_item.q_y > lbm_pkg::VEL_HALF)) ?
                lbm_pkg::VEL_HALF : in_item.q_y;
        if (cfg.fan_velocity > vmax)
            fan_sat = vmax;
        else if (cfg.fan_velocity < -vmax)
            fan_sat = -vmax;
        else
            fan_sat = cfg.fan_velocity;
        ux = '0;
        uy = '0;
        if (in_item.kind == lbm_pkg::KIND_FAN)
            ux = fan_sat;
        else if (in_item.use_div)
        begin
            ux = in_item.neg_x ? -$signed({1'b0, mag_x}) : $signed({1'b0, mag_x});
            uy = in_item.neg_y ? -$signed({1'b0, mag_y}) : $signed({1'b0, mag_y});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            e1_valid_reg <= 1'b0;
        else if (en)
            e1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e1_f_reg    <= in_item.f;
            e1_rho_reg  <= in_item.rho;
            e1_kind_reg <= in_item.kind;
            e1_ux_reg   <= ux;
            e1_uy_reg   <= uy;
        end
    end

    // stage 2: velocity squares and weighted density per class
    logic               e2_valid_reg;
    lbm_pkg::dvec_t     e2_f_reg;
    logic [1:0]         e2_kind_reg;
    logic signed [lbm_pkg::VEL_W-1:0] e2_ux_reg;
    logic signed [lbm_pkg::VEL_W-1:0] e2_uy_reg;
    logic [54:0]        e2_sqx_reg;
    logic [54:0]        e2_sqy_reg;
    logic [28:0]        e2_sqp_reg;
    logic [28:0]        e2_sqm_reg;
    logic [2:0][31:0]   e2_rw_reg;

    logic signed [29:0] sp;
    logic signed [29:0] sm;
    logic signed [57:0] sqx;
    logic signed [57:0] sqy;
    logic signed [59:0] sqp;
    logic signed [59:0] sqm;
    logic signed [31:0] rho_s;
    logic signed [28:0] wgt [3];
    logic signed [60:0] rwp [3];
    logic [2:0][31:0]   rw;

    always_comb
    begin
        sp     = 30'(e1_ux_reg) + 30'(e1_uy_reg);
        sm     = 30'(e1_ux_reg) - 30'(e1_uy_reg);
        sqx    = e1_ux_reg * e1_ux_reg;
        sqy    = e1_uy_reg * e1_uy_reg;
        sqp    = sp * sp;
        sqm    = sm * sm;
        rho_s  = e1_rho_reg;
        wgt[0] = {1'b0, lbm_pkg::W_REST};
        wgt[1] = {1'b0, lbm_pkg::W_AXIS};
        wgt[2] = {1'b0, lbm_pkg::W_DIAG};
        for (int c = 0; c < 3; c++)
        begin
            rwp[c] = rho_s * wgt[c];
            rw[c]  = rwp[c][59:28];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            e2_valid_reg <= 1'b0;
        else if (en)
            e2_valid_reg <= e1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e2_f_reg    <= e1_f_reg;
            e2_kind_reg <= e1_kind_reg;
            e2_ux_reg   <= e1_ux_reg;
            e2_uy_reg   <= e1_uy_reg;
            e2_sqx_reg  <= sqx[54:0];
            e2_sqy_reg  <= sqy[54:0];
            e2_sqp_reg  <= sqp[56:28];
            e2_sqm_reg  <= sqm[56:28];
            e2_rw_reg   <= rw;
        end
    end

    // stage 3: polynomial P for each direction
    logic                 e3_valid_reg;
    lbm_pkg::dvec_t       e3_f_reg;
    logic [1:0]           e3_kind_reg;
    logic [2:0][31:0]     e3_rw_reg;
    logic [8:0][33:0]     e3_p_reg;

    logic [55:0]          u2_full;
    logic [27:0]          u2;
    logic [29:0]          u2_x3;
    logic [28:0]          sqx_s;
    logic [28:0]          sqy_s;
    logic signed [29:0]   vx;
    logic signed [29:0]   vy;
    logic signed [29:0]   ud [lbm_pkg::NDIR];
    logic [28:0]          ud2 [lbm_pkg::NDIR];
    logic [32:0]          ud2_x9;
    logic signed [34:0]   t_one;
    logic signed [34:0]   t_ud;
    logic signed [34:0]   t_ud2;
    logic signed [34:0]   t_u2;
    logic signed [34:0]   p_full;
    logic [8:0][33:0]     p;

    always_comb
    begin
        u2_full = 56'(e2_sqx_reg) + 56'(e2_sqy_reg);
        u2      = u2_full[55:28];
        u2_x3   = 30'(u2) * 30'd3;
        sqx_s   = e2_sqx_reg[54:26] >> 2;
        sqy_s   = e2_sqy_reg[54:26] >> 2;
        vx      = e2_ux_reg;
        vy      = e2_uy_reg;
        ud[0]   = '0;
        ud[1]   = vx;
        ud[2]   = vy;
        ud[3]   = -vx;
        ud[4]   = -vy;
        ud[5]   = vx + vy;
        ud[6]   = vy - vx;
        ud[7]   = -(vx + vy);
        ud[8]   = vx - vy;
        ud2[0]  = '0;
        ud2[1]  = sqx_s;
        ud2[2]  = sqy_s;
        ud2[3]  = sqx_s;
        ud2[4]  = sqy_s;
        ud2[5]  = e2_sqp_reg;
        ud2[6]  = e2_sqm_reg;
        ud2[7]  = e2_sqp_reg;
        ud2[8]  = e2_sqm_reg;
        t_one   = $signed({6'b0, lbm_pkg::ONE});
        t_u2    = $signed({6'b0, u2_x3[29:1]});
        for (int i = 0; i < lbm_pkg::NDIR; i++)
        begin
            ud2_x9 = 33'(ud2[i]) * 33'd9;
            t_ud   = ud[i];
            t_ud   = t_ud * 35'sd3;
            t_ud2  = $signed({3'b0, ud2_x9[32:1]});
            p_full = t_one + t_ud + t_ud2 - t_u2;
            p[i]   = p_full[33:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            e3_valid_reg <= 1'b0;
        else if (en)
            e3_valid_reg <= e2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e3_f_reg    <= e2_f_reg;
            e3_kind_reg <= e2_kind_reg;
            e3_rw_reg   <= e2_rw_reg;
            e3_p_reg    <= p;
        end
    end

    // stage 4: rw * P as two partial products
    logic                 e4_valid_reg;
    lbm_pkg::dvec_t       e4_f_reg;
    logic [1:0]           e4_kind_reg;
    logic [8:0][49:0]     e4_ph_reg;
    logic [8:0][48:0]     e4_pl_reg;

    logic signed [31:0]   rw_d;
    logic signed [17:0]   p_hi;
    logic signed [16:0]   p_lo;
    logic signed [49:0]   prod_h;
    logic signed [48:0]   prod_l;
    logic [8:0][49:0]     ph;
    logic [8:0][48:0]     pl;

    always_comb
    begin
        for (int i = 0; i < lbm_pkg::NDIR; i++)
        begin
            if (i == 0)
                rw_d = e3_rw_reg[0];
            else if (i < 5)
                rw_d = e3_rw_reg[1];
            else
                rw_d = e3_rw_reg[2];
            p_hi   = e3_p_reg[i][33:16];
            p_lo   = {1'b0, e3_p_reg[i][15:0]};
            prod_h = rw_d * p_hi;
            prod_l = rw_d * p_lo;
            ph[i]  = prod_h;
            pl[i]  = prod_l;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            e4_valid_reg <= 1'b0;
        else if (en)
            e4_valid_reg <= e3_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e4_f_reg    <= e3_f_reg;
            e4_kind_reg <= e3_kind_reg;
            e4_ph_reg   <= ph;
            e4_pl_reg   <= pl;
        end
    end

    // stage 5: combine, scale down, saturate
    logic               e5_valid_reg;
    lbm_pkg::rel_item_t e5_item_reg;

    logic signed [67:0] acc_h;
    logic signed [67:0] acc_l;
    logic signed [67:0] acc;
    logic signed [71:0] acc_s;
    lbm_pkg::dvec_t     feq;

    always_comb
    begin
        for (int i = 0; i < lbm_pkg::NDIR; i++)
        begin
            acc_h  = $signed(e4_ph_reg[i]);
            acc_l  = $signed(e4_pl_reg[i]);
            acc    = (acc_h <<< 16) + acc_l;
            acc_s  = acc >>> F;
            feq[i] = lbm_pkg::sat32(acc_s);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            e5_valid_reg <= 1'b0;
        else if (en)
            e5_valid_reg <= e4_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e5_item_reg.f    <= e4_f_reg;
            e5_item_reg.feq  <= feq;
            e5_item_reg.kind <= e4_kind_reg;
        end
    end

    assign out_valid = e5_valid_reg;
    assign out_item  = e5_item_reg;

endmodule

// ===== hw/rtl/lbm_relax.sv =====
// ----------------------------------------------------------------------------
// lbm_relax
// BGK relaxation toward equilibrium; the second stage is the output register.
// ----------------------------------------------------------------------------
module lbm_relax (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  lbm_pkg::rel_item_t in_item,
    input  logic [29:0]        relax_rate,
    output logic               out_valid,
    output lbm_pkg::dvec_t     out_dist,
    output logic [1:0]         out_kind
);

    // stage 1: difference and rate partial products
    logic               r1_valid_reg;
    lbm_pkg::rel_item_t r1_item_reg;
    logic [8:0][47:0]   r1_rh_reg;
    logic [8:0][47:0]   r1_rl_reg;

    logic signed [32:0] fq;
    logic signed [32:0] ff;
    logic signed [32:0] d;
    logic signed [16:0] d_hi;
    logic signed [16:0] d_lo;
    logic signed [30:0] rate_s;
    logic signed [47:0] m_h;
    logic signed [47:0] m_l;
    logic [8:0][47:0]   rh;
    logic [8:0][47:0]   rl;

    always_comb
    begin
        rate_s = {1'b0, relax_rate};
        for (int i = 0; i < lbm_pkg::NDIR; i++)
        begin
            fq    = $signed(in_item.feq[i]);
            ff    = $signed(in_item.f[i]);
            d     = fq - ff;
            d_hi  = d[32:16];
            d_lo  = {1'b0, d[15:0]};
            m_h   = rate_s * d_hi;
            m_l   = rate_s * d_lo;
            rh[i] = m_h;
            rl[i] = m_l;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            r1_valid_reg <= 1'b0;
        else if (en)
            r1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r1_item_reg <= in_item;
            r1_rh_reg   <= rh;
            r1_rl_reg   <= rl;
        end
    end

    // stage 2: new distribution, or equilibrium for boundary cells
    logic           r2_valid_reg;
    lbm_pkg::dvec_t r2_dist_reg;
    logic [1:0]     r2_kind_reg;

    logic signed [65:0] t_h;
    logic signed [65:0] t_l;
    logic signed [65:0] tot;
    logic signed [71:0] delta;
    logic signed [71:0] f_w;
    logic signed [31:0] f_s;
    lbm_pkg::dvec_t     nd;

    always_comb
    begin
        for (int i = 0; i < lbm_pkg::NDIR; i++)
        begin
            t_h   = $signed(r1_rh_reg[i]);
            t_l   = $signed(r1_rl_reg[i]);
            tot   = (t_h <<< 16) + t_l;
            delta = tot >>> lbm_pkg::FRAC_BITS;
            f_s   = r1_item_reg.f[i];
            f_w   = f_s;
            if (r1_item_reg.kind == lbm_pkg::KIND_FLUID)
                nd[i] = lbm_pkg::sat32(f_w + delta);
            else
                nd[i] = r1_item_reg.feq[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            r2_valid_reg <= 1'b0;
        else if (en)
            r2_valid_reg <= r1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r2_dist_reg <= nd;
            r2_kind_reg <= r1_item_reg.kind;
        end
    end

    assign out_valid = r2_valid_reg;
    assign out_dist  = r2_dist_reg;
    assign out_kind  = r2_kind_reg;

endmodule

// ===== hw/rtl/lbm_d2q9_cell_collision.sv =====
// ----------------------------------------------------------------------------
// lbm_d2q9_cell_collision
// D2Q9 BGK collision of one lattice cell with fan and obstacle overrides.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one cell request per beat: coordinates and the nine
//   incoming distributions.  m_axis returns the nine post-collision
//   distributions and the cell kind (fluid, fan, obstacle) in tuser.
//   cfg writes one register per request; cfg_ready is always high.  Users
//   must change registers only while no cell is in flight (not enforced).
// Pipeline:
//   3 front stages, 28 divider stages (one quotient bit of both velocities
//   per stage), 5 equilibrium stages, 2 relaxation stages ending in the
//   output register.  One cell per cycle sustained unless the output stalls.
// Reset:
//   rst_n clears every stage valid bit and loads the register defaults.
// Stall:
//   When m_axis_tready is low with a result waiting, the whole pipeline
//   holds and s_axis_tready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module lbm_d2q9_cell_collision (
    input  logic                            clk,
    input  logic                            rst_n,
    // tdata: cell_x, cell_y, f_rest, f_east, f_north, f_west, f_south,
    //        f_northeast, f_northwest, f_southwest, f_southeast, zero pad
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [lbm_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // tdata: new_rest, new_east, new_north, new_west, new_south,
    //        new_northeast, new_northwest, new_southwest, new_southeast
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [lbm_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // tuser: cell_kind
    output logic [1:0]                      m_axis_tuser,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [lbm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lbm_pkg::CFG_DATA_W-1:0]  cfg_data
);

    // register file
    lbm_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.relax_rate      <= 30'd488064465;
            cfg_reg.fan_velocity    <= 29'sd26843546;
            cfg_reg.obstacle_x      <= 8'd32;
            cfg_reg.obstacle_y      <= 6'd32;
            cfg_reg.obstacle_radius <= 7'd12;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                lbm_pkg::CFG_RELAX:  cfg_reg.relax_rate      <= cfg_data[29:0];
                lbm_pkg::CFG_FAN:    cfg_reg.fan_velocity    <= cfg_data[28:0];
                lbm_pkg::CFG_OBST_X: cfg_reg.obstacle_x      <= cfg_data[7:0];
                lbm_pkg::CFG_OBST_Y: cfg_reg.obstacle_y      <= cfg_data[5:0];
                lbm_pkg::CFG_RADIUS: cfg_reg.obstacle_radius <= cfg_data[6:0];
                default: ;
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    // pipeline advances unless a result is held by the receiver
    logic adv;
    assign adv           = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = adv;

    logic               front_valid;
    lbm_pkg::div_item_t front_item;
    logic               div_valid;
    lbm_pkg::div_item_t div_item;
    logic               eq_valid;
    lbm_pkg::rel_item_t eq_item;
    lbm_pkg::dvec_t     out_dist;

    lbm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (s_axis_tvalid),
        .in_data   (s_axis_tdata),
        .cfg       (cfg_reg),
        .out_valid (front_valid),
        .out_item  (front_item)
    );

    lbm_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (front_valid),
        .in_item   (front_item),
        .out_valid (div_valid),
        .out_item  (div_item)
    );

    lbm_equil u_equil (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (div_valid),
        .in_item   (div_item),
        .cfg       (cfg_reg),
        .out_valid (eq_valid),
        .out_item  (eq_item)
    );

    lbm_relax u_relax (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (adv),
        .in_valid   (eq_valid),
        .in_item    (eq_item),
        .relax_rate (cfg_reg.relax_rate),
        .out_valid  (m_axis_tvalid),
        .out_dist   (out_dist),
        .out_kind   (m_axis_tuser)
    );

    assign m_axis_tdata = out_dist;

`ifndef SYNTH
    // input is refused only while a result is waiting at the output
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with no result pending");

    // obstacle cells sit at zero velocity: opposite and diagonal pairs match
    a_obst_sym: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser == lbm_pkg::KIND_OBST)) |->
        ((m_axis_tdata[63:32] == m_axis_tdata[127:96]) &&
         (m_axis_tdata[95:64] == m_axis_tdata[159:128]) &&
         (m_axis_tdata[191:160] == m_axis_tdata[255:224]) &&
         (m_axis_tdata[223:192] == m_axis_tdata[287:256]) &&
         (m_axis_tdata[191:160] == m_axis_tdata[223:192])))
        else $error("obstacle cell equilibrium not symmetric");

    // fan cells have no y velocity: north/south mirror pairs match
    a_fan_sym: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser == lbm_pkg::KIND_FAN)) |->
        ((m_axis_tdata[95:64] == m_axis_tdata[159:128]) &&
         (m_axis_tdata[191:160] == m_axis_tdata[287:256]) &&
         (m_axis_tdata[223:192] == m_axis_tdata[255:224])))
        else $error("fan cell equilibrium not mirrored in y");
`endif

endmodule
